>>> hdl/sjf_pkg.sv
`default_nettype none

package sjf_pkg;

    localparam int MAX_JOBS  = 16;
    localparam int TIME_BITS = 16;
    localparam int CLK_BITS  = 21;
    localparam int SUM_BITS  = 25;
    localparam int NUM_BITS  = 5;
    localparam int IDX_BITS  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_JOBS + 1);
    localparam int NOW_BITS  = (TIME_BITS > CLK_BITS) ? TIME_BITS : CLK_BITS;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [CLK_BITS-1:0]  clk_t;
    typedef logic [SUM_BITS-1:0]  sum_t;
    typedef logic [NUM_BITS-1:0]  num_t;
    typedef logic [IDX_BITS-1:0]  idx_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [NOW_BITS-1:0]  now_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE,
        ST_FIN,
        ST_TAT,
        ST_WT,
        ST_TSUM,
        ST_WSUM,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_TAT,
        ST_OUT_WT,
        ST_OUT_SEND
    } state_t;

    typedef enum logic [2:0] {
        ALU_IDLE,
        ALU_FIN,
        ALU_TAT,
        ALU_WT,
        ALU_TSUM,
        ALU_WSUM
    } alu_op_t;

    typedef struct packed {
        now_t  clock_now;
        time_t arrival;
        time_t burst;
        clk_t  finish;
        clk_t  turnaround;
        clk_t  waiting;
        sum_t  turnaround_total;
        sum_t  waiting_total;
    } alu_operands_t;

    typedef struct packed {
        logic  found;
        idx_t  pick;
        time_t best_burst;
        time_t pick_arrival;
        time_t earliest;
    } scan_result_t;

endpackage

`default_nettype wire

>>> hdl/sjf_store.sv
`default_nettype none

module sjf_store (
    input  wire logic           clk,
    input  wire logic           load_en,
    input  wire sjf_pkg::idx_t  load_addr,
    input  wire sjf_pkg::time_t load_arrival,
    input  wire sjf_pkg::time_t load_burst,
    input  wire logic           fin_en,
    input  wire sjf_pkg::idx_t  fin_addr,
    input  wire sjf_pkg::clk_t  fin_data,
    input  wire sjf_pkg::idx_t  rd_addr,
    output sjf_pkg::time_t      rd_arrival,
    output sjf_pkg::time_t      rd_burst,
    output sjf_pkg::clk_t       rd_finish
);

    sjf_pkg::time_t arrival_mem [sjf_pkg::MAX_JOBS];
    sjf_pkg::time_t burst_mem   [sjf_pkg::MAX_JOBS];
    sjf_pkg::clk_t  finish_mem  [sjf_pkg::MAX_JOBS];

    sjf_pkg::time_t rd_arrival_reg;
    sjf_pkg::time_t rd_burst_reg;
    sjf_pkg::clk_t  rd_finish_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            arrival_mem[load_addr] <= load_arrival;
            burst_mem[load_addr]   <= load_burst;
        end
        if (fin_en)
        begin
            finish_mem[fin_addr] <= fin_data;
        end
        rd_arrival_reg <= arrival_mem[rd_addr];
        rd_burst_reg   <= burst_mem[rd_addr];
        rd_finish_reg  <= finish_mem[rd_addr];
    end

    assign rd_arrival = rd_arrival_reg;
    assign rd_burst   = rd_burst_reg;
    assign rd_finish  = rd_finish_reg;

endmodule

`default_nettype wire

>>> hdl/sjf_scan_unit.sv
`default_nettype none

module sjf_scan_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           clear,
    input  wire logic           eval,
    input  wire sjf_pkg::idx_t  idx,
    input  wire sjf_pkg::time_t arrival,
    input  wire sjf_pkg::time_t burst,
    input  wire logic           finished,
    input  wire sjf_pkg::now_t  clock_now,
    output sjf_pkg::scan_result_t result
);

    logic           found_reg, found_next;
    logic           any_left_reg, any_left_next;
    sjf_pkg::idx_t  pick_reg, pick_next;
    sjf_pkg::time_t best_reg, best_next;
    sjf_pkg::time_t pick_arr_reg, pick_arr_next;
    sjf_pkg::time_t earliest_reg, earliest_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            any_left_reg <= 1'b0;
        end
        else
        begin
            found_reg    <= found_next;
            any_left_reg <= any_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg     <= pick_next;
        best_reg     <= best_next;
        pick_arr_reg <= pick_arr_next;
        earliest_reg <= earliest_next;
    end

    always_comb
    begin
        found_next    = found_reg;
        any_left_next = any_left_reg;
        pick_next     = pick_reg;
        best_next     = best_reg;
        pick_arr_next = pick_arr_reg;
        earliest_next = earliest_reg;
        if (clear)
        begin
            found_next    = 1'b0;
            any_left_next = 1'b0;
        end
        else if (eval && !finished)
        begin
            if (!any_left_reg || (arrival < earliest_reg))
            begin
                earliest_next = arrival;
            end
            any_left_next = 1'b1;
            // only jobs already arrived compete; strict less keeps the lowest index
            if ((sjf_pkg::now_t'(arrival) <= clock_now) && (!found_reg || (burst < best_reg)))
            begin
                found_next    = 1'b1;
                pick_next     = idx;
                best_next     = burst;
                pick_arr_next = arrival;
            end
        end
    end

    assign result.found        = found_reg;
    assign result.pick         = pick_reg;
    assign result.best_burst   = best_reg;
    assign result.pick_arrival = pick_arr_reg;
    assign result.earliest     = earliest_reg;

endmodule

`default_nettype wire

>>> hdl/sjf_alu.sv
`default_nettype none

module sjf_alu (
    input  wire sjf_pkg::alu_op_t       op,
    input  wire sjf_pkg::alu_operands_t opnd,
    output sjf_pkg::sum_t               result
);

    sjf_pkg::sum_t a;
    sjf_pkg::sum_t b;
    sjf_pkg::sum_t raw;
    logic          sub;
    logic          narrow;

    always_comb
    begin
        a      = '0;
        b      = '0;
        sub    = 1'b0;
        narrow = 1'b0;
        case (op)
            sjf_pkg::ALU_FIN:
            begin
                a      = sjf_pkg::sum_t'(opnd.clock_now);
                b      = sjf_pkg::sum_t'(opnd.burst);
                narrow = 1'b1;
            end
            sjf_pkg::ALU_TAT:
            begin
                a      = sjf_pkg::sum_t'(opnd.finish);
                b      = sjf_pkg::sum_t'(opnd.arrival);
                sub    = 1'b1;
                narrow = 1'b1;
            end
            sjf_pkg::ALU_WT:
            begin
                a      = sjf_pkg::sum_t'(opnd.turnaround);
                b      = sjf_pkg::sum_t'(opnd.burst);
                sub    = 1'b1;
                narrow = 1'b1;
            end
            sjf_pkg::ALU_TSUM:
            begin
                a = opnd.turnaround_total;
                b = sjf_pkg::sum_t'(opnd.turnaround);
            end
            sjf_pkg::ALU_WSUM:
            begin
                a = opnd.waiting_total;
                b = sjf_pkg::sum_t'(opnd.waiting);
            end
            default:
            begin
                a = '0;
                b = '0;
            end
        endcase
        raw    = sub ? (a - b) : (a + b);
        // wrap time values to the clock width
        result = narrow ? sjf_pkg::sum_t'(sjf_pkg::clk_t'(raw)) : raw;
    end

endmodule

`default_nettype wire

>>> hdl/sjf_nonpreemptive_scheduler_core.sv
`default_nettype none

// Channel | Direction | Handshake                   | Word
// job     | in        | job_valid / job_ready       | arrival_time, burst_length, last_job
// result  | out       | result_valid / result_ready | job_number .. last_result
//
// Loading accepts one job word per cycle; a word with last_job set starts the run.
// Each selection scans all N stored jobs through the store read port, then runs decide
// and the shared-adder steps fin, tat, wt, tsum, wsum; a jump to the next arrival costs
// a decide step and a rescan. Each result passes read, load, tat, wt before result_valid.
// Reset clears job count, clock, totals and finished flags; job_ready is high only
// while loading, and the run and the result stream block new jobs until the last word.

module sjf_nonpreemptive_scheduler_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_valid,
    output logic                job_ready,
    input  wire sjf_pkg::time_t arrival_time,
    input  wire sjf_pkg::time_t burst_length,
    input  wire logic           last_job,
    output logic                result_valid,
    input  wire logic           result_ready,
    output sjf_pkg::num_t       job_number,
    output sjf_pkg::clk_t       completion_time,
    output sjf_pkg::clk_t       turnaround_time,
    output sjf_pkg::clk_t       waiting_time,
    output sjf_pkg::sum_t       turnaround_sum,
    output sjf_pkg::sum_t       waiting_sum,
    output logic                last_result
);

    sjf_pkg::state_t state_reg, state_next;
    sjf_pkg::cnt_t   count_reg, count_next;
    sjf_pkg::cnt_t   done_cnt_reg, done_cnt_next;
    sjf_pkg::cnt_t   issue_cnt_reg, issue_cnt_next;
    logic            vld_d_reg, vld_d_next;
    sjf_pkg::idx_t   out_idx_reg, out_idx_next;
    sjf_pkg::now_t   clock_now_reg, clock_now_next;
    sjf_pkg::sum_t   tsum_reg, tsum_next;
    sjf_pkg::sum_t   wsum_reg, wsum_next;
    logic [sjf_pkg::MAX_JOBS-1:0] flags_reg, flags_next;

    sjf_pkg::idx_t   idx_d_reg, idx_d_next;
    sjf_pkg::time_t  arr_op_reg, arr_op_next;
    sjf_pkg::time_t  bur_op_reg, bur_op_next;
    sjf_pkg::clk_t   fin_reg, fin_next;
    sjf_pkg::clk_t   tat_reg, tat_next;
    sjf_pkg::clk_t   wt_reg, wt_next;

    logic                  load_en;
    logic                  fin_en;
    logic                  scan_clear;
    sjf_pkg::idx_t         rd_addr;
    sjf_pkg::time_t        rd_arrival;
    sjf_pkg::time_t        rd_burst;
    sjf_pkg::clk_t         rd_finish;
    sjf_pkg::scan_result_t scan_res;
    sjf_pkg::alu_op_t      alu_op;
    sjf_pkg::alu_operands_t alu_opnd;
    sjf_pkg::sum_t         alu_result;
    sjf_pkg::cnt_t         out_pos;
    logic                  out_last;

    sjf_store u_store (
        .clk          (clk),
        .load_en      (load_en),
        .load_addr    (sjf_pkg::idx_t'(count_reg)),
        .load_arrival (arrival_time),
        .load_burst   (burst_length),
        .fin_en       (fin_en),
        .fin_addr     (scan_res.pick),
        .fin_data     (sjf_pkg::clk_t'(alu_result)),
        .rd_addr      (rd_addr),
        .rd_arrival   (rd_arrival),
        .rd_burst     (rd_burst),
        .rd_finish    (rd_finish)
    );

    sjf_scan_unit u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (scan_clear),
        .eval      (vld_d_reg),
        .idx       (idx_d_reg),
        .arrival   (rd_arrival),
        .burst     (rd_burst),
        .finished  (flags_reg[idx_d_reg]),
        .clock_now (clock_now_reg),
        .result    (scan_res)
    );

    assign alu_opnd.clock_now        = clock_now_reg;
    assign alu_opnd.arrival          = arr_op_reg;
    assign alu_opnd.burst            = bur_op_reg;
    assign alu_opnd.finish           = fin_reg;
    assign alu_opnd.turnaround       = tat_reg;
    assign alu_opnd.waiting          = wt_reg;
    assign alu_opnd.turnaround_total = tsum_reg;
    assign alu_opnd.waiting_total    = wsum_reg;

    sjf_alu u_alu (
        .op     (alu_op),
        .opnd   (alu_opnd),
        .result (alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sjf_pkg::ST_LOAD;
            count_reg     <= '0;
            done_cnt_reg  <= '0;
            issue_cnt_reg <= '0;
            vld_d_reg     <= 1'b0;
            out_idx_reg   <= '0;
            clock_now_reg <= '0;
            tsum_reg      <= '0;
            wsum_reg      <= '0;
            flags_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            done_cnt_reg  <= done_cnt_next;
            issue_cnt_reg <= issue_cnt_next;
            vld_d_reg     <= vld_d_next;
            out_idx_reg   <= out_idx_next;
            clock_now_reg <= clock_now_next;
            tsum_reg      <= tsum_next;
            wsum_reg      <= wsum_next;
            flags_reg     <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_d_reg  <= idx_d_next;
        arr_op_reg <= arr_op_next;
        bur_op_reg <= bur_op_next;
        fin_reg    <= fin_next;
        tat_reg    <= tat_next;
        wt_reg     <= wt_next;
    end

    assign out_pos  = sjf_pkg::cnt_t'(out_idx_reg) + sjf_pkg::cnt_t'(1);
    assign out_last = (out_pos == count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        done_cnt_next  = done_cnt_reg;
        issue_cnt_next = issue_cnt_reg;
        vld_d_next     = 1'b0;
        out_idx_next   = out_idx_reg;
        clock_now_next = clock_now_reg;
        tsum_next      = tsum_reg;
        wsum_next      = wsum_reg;
        flags_next     = flags_reg;
        idx_d_next     = idx_d_reg;
        arr_op_next    = arr_op_reg;
        bur_op_next    = bur_op_reg;
        fin_next       = fin_reg;
        tat_next       = tat_reg;
        wt_next        = wt_reg;
        load_en        = 1'b0;
        fin_en         = 1'b0;
        scan_clear     = 1'b0;
        rd_addr        = sjf_pkg::idx_t'(issue_cnt_reg);
        alu_op         = sjf_pkg::ALU_IDLE;

        case (state_reg)
            sjf_pkg::ST_LOAD:
            begin
                if (job_valid)
                begin
                    // drop jobs beyond capacity, but still honor the closing flag
                    if (count_reg < sjf_pkg::cnt_t'(sjf_pkg::MAX_JOBS))
                    begin
                        load_en    = 1'b1;
                        count_next = count_reg + sjf_pkg::cnt_t'(1);
                    end
                    if (last_job)
                    begin
                        issue_cnt_next = '0;
                        scan_clear     = 1'b1;
                        state_next     = sjf_pkg::ST_SCAN;
                    end
                end
            end
            sjf_pkg::ST_SCAN:
            begin
                if (issue_cnt_reg < count_reg)
                begin
                    vld_d_next     = 1'b1;
                    idx_d_next     = sjf_pkg::idx_t'(issue_cnt_reg);
                    issue_cnt_next = issue_cnt_reg + sjf_pkg::cnt_t'(1);
                end
                else if (!vld_d_reg)
                begin
                    state_next = sjf_pkg::ST_DECIDE;
                end
            end
            sjf_pkg::ST_DECIDE:
            begin
                if (!scan_res.found)
                begin
                    // nothing has arrived: advance to the next arrival and rescan
                    clock_now_next = sjf_pkg::now_t'(scan_res.earliest);
                    issue_cnt_next = '0;
                    scan_clear     = 1'b1;
                    state_next     = sjf_pkg::ST_SCAN;
                end
                else
                begin
                    flags_next[scan_res.pick] = 1'b1;
                    arr_op_next = scan_res.pick_arrival;
                    bur_op_next = scan_res.best_burst;
                    state_next  = sjf_pkg::ST_FIN;
                end
            end
            sjf_pkg::ST_FIN:
            begin
                alu_op         = sjf_pkg::ALU_FIN;
                fin_en         = 1'b1;
                fin_next       = sjf_pkg::clk_t'(alu_result);
                clock_now_next = sjf_pkg::now_t'(sjf_pkg::clk_t'(alu_result));
                state_next     = sjf_pkg::ST_TAT;
            end
            sjf_pkg::ST_TAT:
            begin
                alu_op     = sjf_pkg::ALU_TAT;
                tat_next   = sjf_pkg::clk_t'(alu_result);
                state_next = sjf_pkg::ST_WT;
            end
            sjf_pkg::ST_WT:
            begin
                alu_op     = sjf_pkg::ALU_WT;
                wt_next    = sjf_pkg::clk_t'(alu_result);
                state_next = sjf_pkg::ST_TSUM;
            end
            sjf_pkg::ST_TSUM:
            begin
                alu_op     = sjf_pkg::ALU_TSUM;
                tsum_next  = alu_result;
                state_next = sjf_pkg::ST_WSUM;
            end
            sjf_pkg::ST_WSUM:
            begin
                alu_op        = sjf_pkg::ALU_WSUM;
                wsum_next     = alu_result;
                done_cnt_next = done_cnt_reg + sjf_pkg::cnt_t'(1);
                if (done_cnt_next == count_reg)
                begin
                    out_idx_next = '0;
                    state_next   = sjf_pkg::ST_OUT_RD;
                end
                else
                begin
                    issue_cnt_next = '0;
                    scan_clear     = 1'b1;
                    state_next     = sjf_pkg::ST_SCAN;
                end
            end
            sjf_pkg::ST_OUT_RD:
            begin
                rd_addr    = out_idx_reg;
                state_next = sjf_pkg::ST_OUT_LD;
            end
            sjf_pkg::ST_OUT_LD:
            begin
                arr_op_next = rd_arrival;
                bur_op_next = rd_burst;
                fin_next    = rd_finish;
                state_next  = sjf_pkg::ST_OUT_TAT;
            end
            sjf_pkg::ST_OUT_TAT:
            begin
                alu_op     = sjf_pkg::ALU_TAT;
                tat_next   = sjf_pkg::clk_t'(alu_result);
                state_next = sjf_pkg::ST_OUT_WT;
            end
            sjf_pkg::ST_OUT_WT:
            begin
                alu_op     = sjf_pkg::ALU_WT;
                wt_next    = sjf_pkg::clk_t'(alu_result);
                state_next = sjf_pkg::ST_OUT_SEND;
            end
            sjf_pkg::ST_OUT_SEND:
            begin
                if (result_ready)
                begin
                    if (out_last)
                    begin
                        // set done: clear for the next set
                        count_next     = '0;
                        done_cnt_next  = '0;
                        clock_now_next = '0;
                        tsum_next      = '0;
                        wsum_next      = '0;
                        flags_next     = '0;
                        state_next     = sjf_pkg::ST_LOAD;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + sjf_pkg::idx_t'(1);
                        state_next   = sjf_pkg::ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = sjf_pkg::ST_LOAD;
            end
        endcase
    end

    assign job_ready       = (state_reg == sjf_pkg::ST_LOAD);
    assign result_valid    = (state_reg == sjf_pkg::ST_OUT_SEND);
    assign job_number      = sjf_pkg::num_t'(out_pos);
    assign completion_time = fin_reg;
    assign turnaround_time = tat_reg;
    assign waiting_time    = wt_reg;
    assign turnaround_sum  = out_last ? tsum_reg : '0;
    assign waiting_sum     = out_last ? wsum_reg : '0;
    assign last_result     = out_last;

endmodule

`default_nettype wire

>>> hdl/sjf_checker.sv
`default_nettype none

module sjf_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           job_valid,
    input wire logic           job_ready,
    input wire logic           last_job,
    input wire logic           result_valid,
    input wire logic           result_ready,
    input wire sjf_pkg::num_t  job_number,
    input wire sjf_pkg::clk_t  completion_time,
    input wire sjf_pkg::sum_t  turnaround_sum,
    input wire sjf_pkg::sum_t  waiting_sum,
    input wire logic           last_result
);

    // loading and delivering never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(job_ready && result_valid))
        else $error("job_ready and result_valid high together");

    a_close_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && job_ready && last_job) |=> !job_ready)
        else $error("closing word did not start the run");

    a_more_results: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !last_result) |=> !job_ready)
        else $error("loading resumed before the final result");

    a_sums_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_result) |-> (turnaround_sum == '0 && waiting_sum == '0))
        else $error("totals shown on a result that is not the last");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(job_number) && $stable(completion_time)))
        else $error("stalled result word changed");

endmodule

bind sjf_nonpreemptive_scheduler_core sjf_checker u_sjf_checker (.*);

`default_nettype wire
